>>> design/tdc_pkg.sv
// Shared types, constants and digit helpers for the time-of-day clock core.
// No dependencies; imported by every module of the block.
package tdc_pkg;

   localparam int unsigned ByteW      = 8;
   localparam int unsigned TickW      = 16;
   localparam int unsigned PosW       = 9;
   localparam int unsigned BurstLen   = 8;
   localparam int unsigned BurstIdxW  = $clog2(BurstLen);
   localparam int unsigned PayloadLen = 8;
   localparam int unsigned PayIdxW    = $clog2(PayloadLen);

   localparam logic [ByteW-1:0] HeadByte  = 8'h50;
   localparam logic [ByteW-1:0] TailByte  = 8'h43;
   localparam logic [ByteW-1:0] DigitBase = 8'h30;
   localparam logic [ByteW-1:0] ColonByte = 8'h3A;
   localparam logic [ByteW-1:0] SetLength = 8'd8;
   localparam logic [ByteW-1:0] SecPerMin = 8'd60;
   localparam logic [ByteW-1:0] MinPerHr  = 8'd60;
   localparam logic [ByteW-1:0] HrPerDay  = 8'd24;
   localparam logic [TickW-1:0] TicksPerSecondReset = 16'd100;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_BYTE = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic                             valid;
      logic [BurstIdxW-1:0]             last_idx;
      logic [BurstLen-1:0][ByteW-1:0]   bytes;
   } burst_type;

   // exact for 0..255: q = (v * 205) >> 11
   function automatic logic [ByteW-1:0] div10(input logic [ByteW-1:0] v);
      logic [15:0] prod;
      prod = {8'd0, v} * 16'd205;
      return prod[15:11] == 5'd0 ? 8'd0 : {3'd0, prod[15:11]};
   endfunction

   function automatic logic [ByteW-1:0] tens_char(input logic [ByteW-1:0] v);
      return div10(v) + DigitBase;
   endfunction

   function automatic logic [ByteW-1:0] ones_char(input logic [ByteW-1:0] v);
      logic [ByteW-1:0] q;
      logic [ByteW-1:0] r;
      q = div10(v);
      r = v - ((q << 3) + (q << 1));
      return r + DigitBase;
   endfunction

   function automatic logic [ByteW-1:0] pair_value(input logic [ByteW-1:0] tens,
                                                   input logic [ByteW-1:0] ones);
      logic [ByteW-1:0] t;
      t = tens - DigitBase;
      return (t << 3) + (t << 1) + (ones - DigitBase);
   endfunction

endpackage

>>> design/tdc_time_core.sv
// Clock state, tick divider, frame parser and time-set path of the core.
// Builds at most one output burst per item from the registered input beat; uses tdc_pkg.
module tdc_time_core import tdc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [TickW-1:0] csr_wr_data,
   input  logic             fire,
   input  item_kind_type    item_kind,
   input  logic [ByteW-1:0] item_byte,
   output burst_type        burst
);

   logic [TickW-1:0] tps_ff, tps_in;
   logic [TickW-1:0] tick_ff, tick_in;
   logic [ByteW-1:0] hours_ff, hours_in;
   logic [ByteW-1:0] minutes_ff, minutes_in;
   logic [ByteW-1:0] seconds_ff, seconds_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [ByteW-1:0] len_ff, len_in;
   logic [PayloadLen-1:0][ByteW-1:0] pay_ff, pay_in;

   logic [TickW-1:0] tick_next;
   logic             print;
   logic [ByteW-1:0] sec_inc, min_inc, hr_inc;
   logic [PosW-1:0]  pay_end;
   logic [PosW-1:0]  pay_idx;
   logic             good_frame;

   always_comb begin
      tps_in     = csr_wr_en ? csr_wr_data : tps_ff;
      tick_in    = tick_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      pay_in     = pay_ff;
      good_frame = 1'b0;

      tick_next = tick_ff + 16'd1;
      print     = !(tick_next < tps_ff);
      sec_inc   = seconds_ff + 8'd1;
      min_inc   = minutes_ff + 8'd1;
      hr_inc    = hours_ff + 8'd1;
      pay_end   = {1'b0, len_ff} + 9'd1;
      pay_idx   = pos_ff - 9'd2;

      burst.valid    = 1'b0;
      burst.last_idx = '0;
      burst.bytes    = '0;

      if (item_kind == KIND_BYTE) begin
         burst.valid    = 1'b1;
         burst.bytes[0] = item_byte;
      end else if (print) begin
         burst.valid    = 1'b1;
         burst.last_idx = BurstIdxW'(BurstLen - 1);
         burst.bytes[0] = tens_char(hours_ff);
         burst.bytes[1] = ones_char(hours_ff);
         burst.bytes[2] = ColonByte;
         burst.bytes[3] = tens_char(minutes_ff);
         burst.bytes[4] = ones_char(minutes_ff);
         burst.bytes[5] = ColonByte;
         burst.bytes[6] = tens_char(seconds_ff);
         burst.bytes[7] = ones_char(seconds_ff);
      end

      if (fire) begin
         if (item_kind == KIND_BYTE) begin
            if (pos_ff == '0) begin
               if (item_byte == HeadByte) pos_in = 9'd1;
            end else if (pos_ff == 9'd1) begin
               len_in = item_byte - DigitBase;
               pos_in = 9'd2;
            end else if (pos_ff <= pay_end) begin
               if (pay_idx < 9'(PayloadLen)) pay_in[pay_idx[PayIdxW-1:0]] = item_byte;
               pos_in = pos_ff + 9'd1;
            end else begin
               pos_in     = '0;
               good_frame = item_byte == TailByte;
            end
            if (good_frame && len_ff == SetLength) begin
               hours_in   = pair_value(pay_ff[0], pay_ff[1]);
               minutes_in = pair_value(pay_ff[3], pay_ff[4]);
               seconds_in = pair_value(pay_ff[6], pay_ff[7]);
            end
         end else if (!print) begin
            tick_in = tick_next;
         end else begin
            tick_in    = '0;
            seconds_in = sec_inc;
            if (!(sec_inc < SecPerMin)) begin
               seconds_in = '0;
               minutes_in = min_inc;
               if (!(min_inc < MinPerHr)) begin
                  minutes_in = '0;
                  hours_in   = (hr_inc < HrPerDay) ? hr_inc : '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff     <= TicksPerSecondReset;
         tick_ff    <= '0;
         hours_ff   <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
         pos_ff     <= '0;
         len_ff     <= '0;
      end else begin
         tps_ff     <= tps_in;
         tick_ff    <= tick_in;
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
      end
      pay_ff <= pay_in;
   end

endmodule

>>> design/tdc_tx_serializer.sv
// Output register of the core: holds one burst of up to eight bytes and shifts it out.
// Uses burst_type from tdc_pkg.
module tdc_tx_serializer import tdc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  burst_type        burst,
   output logic             can_load,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ByteW-1:0] rsp_tx_byte,
   output logic             rsp_last
);

   logic                           busy_ff, busy_in;
   logic [BurstIdxW-1:0]           left_ff, left_in;
   logic [BurstLen-1:0][ByteW-1:0] bytes_ff, bytes_in;
   logic                           pop;

   always_comb begin
      pop      = busy_ff && rsp_ready;
      can_load = !busy_ff || (pop && left_ff == '0);
      busy_in  = busy_ff;
      left_in  = left_ff;
      bytes_in = bytes_ff;
      if (pop) begin
         bytes_in = {{ByteW{1'b0}}, bytes_ff[BurstLen-1:1]};
         left_in  = left_ff - 1'b1;
         if (left_ff == '0) busy_in = 1'b0;
      end
      if (load && burst.valid) begin
         bytes_in = burst.bytes;
         left_in  = burst.last_idx;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         left_ff <= left_in;
      end
      bytes_ff <= bytes_in;
   end

   assign rsp_valid   = busy_ff;
   assign rsp_tx_byte = bytes_ff[0];
   assign rsp_last    = left_ff == '0;

endmodule

>>> design/serial_settable_time_of_day_clock_core.sv
// Top level of the serial settable time-of-day clock core.
// Instantiates tdc_time_core and tdc_tx_serializer; uses tdc_pkg.
//
// Usage:
//   req channel: one beat is a timer tick (req_type 0) or a received serial
//   byte (req_type 1, req_rx_byte). rsp channel: bytes to transmit, with
//   rsp_last high on the final byte of the run caused by one req beat.
//   csr_wr_en/csr_wr_data write ticks_per_second (reset value 100).
//   A received byte gives one echo beat; every ticks_per_second-th tick gives
//   the eight beats "hh:mm:ss" and then advances the time; other ticks give none.
// Path: an accepted req beat waits in the input register until the output register can
//   take its burst; the first rsp beat then comes from the output register.
// Throughput: one req beat per cycle while each yields at most one rsp beat and
//   rsp_ready stays high; a printing tick holds the output register until all eight
//   bytes of its burst are shifted out, and no new item is loaded before that.
// Stall: when rsp_ready is low the output burst holds, the input register fills
//   and req_ready drops until the burst drains.
// Reset: synchronous, active high; clears time, tick count, frame parser and
//   both registers' valid flags. Payload bytes are not cleared.
module serial_settable_time_of_day_clock_core import tdc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_type,
   input  logic [ByteW-1:0] req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ByteW-1:0] rsp_tx_byte,
   output logic             rsp_last,
   input  logic             csr_wr_en,
   input  logic [TickW-1:0] csr_wr_data
);

   logic             in_valid_ff, in_valid_in;
   item_kind_type    in_kind_ff, in_kind_in;
   logic [ByteW-1:0] in_byte_ff, in_byte_in;
   logic             can_load;
   logic             fire;
   logic             accept;
   burst_type        burst;

   always_comb begin
      fire        = in_valid_ff && can_load;
      req_ready   = !in_valid_ff || can_load;
      accept      = req_valid && req_ready;
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_kind_in  = item_kind_type'(req_type);
         in_byte_in  = req_rx_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_kind_ff <= in_kind_in;
      in_byte_ff <= in_byte_in;
   end

   tdc_time_core u_time_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item_kind   (in_kind_ff),
      .item_byte   (in_byte_ff),
      .burst       (burst)
   );

   tdc_tx_serializer u_tx_serializer (
      .clock       (clock),
      .reset       (reset),
      .load        (fire),
      .burst       (burst),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

endmodule

>>> design/tdc_checker.sv
// Port-level checks of the time-of-day clock core, bound to the top level.
// Uses tdc_pkg constants; sees only the top level's ports.
module tdc_checker import tdc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [ByteW-1:0] rsp_tx_byte,
   input logic             rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a time run");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("req beat dropped while stalled");

endmodule

bind serial_settable_time_of_day_clock_core tdc_checker u_tdc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_tx_byte (rsp_tx_byte),
   .rsp_last    (rsp_last)
);

>>> verif/serial_settable_time_of_day_clock_core_test.sv
// Self-checking testbench for serial_settable_time_of_day_clock_core, checked beat by beat:
// directed table vs. its own bytes, then random ticks, set-time frames, noise vs. a predictor.
// Depends on tdc_pkg and the core RTL only.
`timescale 1ns / 1ps

module serial_settable_time_of_day_clock_core_test import tdc_pkg::*;;

   typedef struct packed {
      logic [ByteW-1:0] tx_byte;
      logic             last;
   } tx_beat_type;

   typedef struct packed {
      bit               is_cfg;
      item_kind_type    kind;
      logic [TickW-1:0] data;
      bit               typed;
      logic [63:0]      want;
   } step_row_type;

   localparam int ScriptLen = 26;
   localparam step_row_type Script [ScriptLen] = '{
      '{1'b1, KIND_TICK, 16'd1,    1'b0, 64'h0},
      '{1'b0, KIND_TICK, 16'h00a5, 1'b1, "00:00:00"},
      '{1'b0, KIND_TICK, 16'h005a, 1'b1, "00:00:01"},
      '{1'b0, KIND_BYTE, 16'h0000, 1'b1, 64'h00},
      '{1'b0, KIND_BYTE, 16'h00ff, 1'b1, 64'hff},
      '{1'b0, KIND_BYTE, 16'h0050, 1'b1, 64'h50},
      '{1'b0, KIND_BYTE, 16'h0038, 1'b1, 64'h38},
      '{1'b0, KIND_BYTE, 16'h0032, 1'b1, 64'h32},
      '{1'b0, KIND_BYTE, 16'h0033, 1'b1, 64'h33},
      '{1'b0, KIND_BYTE, 16'h003a, 1'b1, 64'h3a},
      '{1'b0, KIND_BYTE, 16'h0035, 1'b1, 64'h35},
      '{1'b0, KIND_BYTE, 16'h0039, 1'b1, 64'h39},
      '{1'b0, KIND_BYTE, 16'h003a, 1'b1, 64'h3a},
      '{1'b0, KIND_BYTE, 16'h003a, 1'b1, 64'h3a},
      '{1'b0, KIND_BYTE, 16'h0039, 1'b1, 64'h39},
      '{1'b0, KIND_BYTE, 16'h0043, 1'b1, 64'h43},
      '{1'b0, KIND_TICK, 16'h00c3, 1'b1, "23:59::9"},
      '{1'b0, KIND_TICK, 16'h003c, 1'b1, "00:00:00"},
      '{1'b0, KIND_BYTE, 16'h0050, 1'b1, 64'h50},
      '{1'b0, KIND_BYTE, 16'h0030, 1'b1, 64'h30},
      '{1'b0, KIND_BYTE, 16'h0058, 1'b1, 64'h58},
      '{1'b1, KIND_TICK, 16'd0,    1'b0, 64'h0},
      '{1'b0, KIND_TICK, 16'h00ff, 1'b0, 64'h0},
      '{1'b1, KIND_TICK, 16'hffff, 1'b0, 64'h0},
      '{1'b0, KIND_TICK, 16'h0000, 1'b0, 64'h0},
      '{1'b0, KIND_TICK, 16'h0081, 1'b0, 64'h0}
   };

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   logic             req_type    = KIND_TICK;
   logic [ByteW-1:0] req_rx_byte = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   logic [ByteW-1:0] rsp_tx_byte;
   logic             rsp_last;
   logic             csr_wr_en   = 1'b0;
   logic [TickW-1:0] csr_wr_data = '0;

   logic [TickW-1:0] tick_limit  = TicksPerSecondReset;
   logic [TickW-1:0] tick_tally  = '0;
   logic [ByteW-1:0] tod_hours   = '0;
   logic [ByteW-1:0] tod_minutes = '0;
   logic [ByteW-1:0] tod_seconds = '0;
   logic [PosW-1:0]  frame_pos   = '0;
   logic [ByteW-1:0] frame_len   = '0;
   logic [ByteW-1:0] payload [PayloadLen];

   tx_beat_type tx_due [$];
   tx_beat_type fresh [$];
   int     mismatches   = 0;
   int     beats_sent   = 0;
   bit     steady_run   = 1'b0;
   bit     hold_off_ask = 1'b0;
   bit     want_long    = 1'b0;

   serial_settable_time_of_day_clock_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [ByteW-1:0] digit_pair(input logic [ByteW-1:0] tens,
                                                   input logic [ByteW-1:0] ones);
      logic [ByteW-1:0] t;
      t = tens - DigitBase;
      return ByteW'(t * 8'd10) + ByteW'(ones - DigitBase);
   endfunction

   function automatic void predict_tx(input item_kind_type kind, input logic [ByteW-1:0] data);
      logic [ByteW-1:0] shown [8];
      fresh.delete();
      if (kind == KIND_BYTE) begin
         if (frame_pos == 0) begin
            if (data == HeadByte) frame_pos = 9'd1;
         end else if (frame_pos == 1) begin
            frame_len = data - DigitBase;
            frame_pos = 9'd2;
         end else if (frame_pos <= {1'b0, frame_len} + 9'd1) begin
            if (frame_pos - 9'd2 < PayloadLen) payload[PayIdxW'(frame_pos - 9'd2)] = data;
            frame_pos = frame_pos + 9'd1;
         end else begin
            frame_pos = '0;
            if (data == TailByte && frame_len == SetLength) begin
               tod_hours   = digit_pair(payload[0], payload[1]);
               tod_minutes = digit_pair(payload[3], payload[4]);
               tod_seconds = digit_pair(payload[6], payload[7]);
            end
         end
         fresh.push_back('{data, 1'b1});
         return;
      end
      tick_tally = tick_tally + 1'b1;
      if (tick_tally < tick_limit) return;
      tick_tally = '0;
      shown = '{tod_hours / 8'd10 + DigitBase, tod_hours % 8'd10 + DigitBase, ColonByte,
                tod_minutes / 8'd10 + DigitBase, tod_minutes % 8'd10 + DigitBase, ColonByte,
                tod_seconds / 8'd10 + DigitBase, tod_seconds % 8'd10 + DigitBase};
      for (int i = 0; i < 8; i++) fresh.push_back('{shown[i], i == 7});
      tod_seconds = tod_seconds + 8'd1;
      if (tod_seconds >= SecPerMin) begin
         tod_seconds = '0;
         tod_minutes = tod_minutes + 8'd1;
         if (tod_minutes >= MinPerHr) begin
            tod_minutes = '0;
            tod_hours = tod_hours + 8'd1;
            if (tod_hours >= HrPerDay) tod_hours = '0;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [ByteW-1:0] got,
                                  input logic [ByteW-1:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : rsp_check
      tx_beat_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tx_due.size() == 0) begin
            report_mismatch("beat with nothing due", rsp_tx_byte, 8'h00);
         end else begin
            due = tx_due.pop_front();
            if (rsp_tx_byte !== due.tx_byte) report_mismatch("tx_byte", rsp_tx_byte, due.tx_byte);
            if (rsp_last !== due.last)
               report_mismatch("last", ByteW'(rsp_last), ByteW'(due.last));
         end
      end
   end

   initial begin : rsp_side
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_off_ask) begin
            hold_off_ask = 1'b0;
            hold = 150;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_run || ($urandom_range(99) >= 26);
         end
      end
   end

   // enter and leave at a falling edge
   task automatic send_beat(input item_kind_type kind, input logic [ByteW-1:0] data,
                            input bit typed = 1'b0, input logic [63:0] want = '0);
      if (!steady_run && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_rx_byte <= data;
      do @(posedge clock); while (!req_ready);
      predict_tx(kind, data);
      if (!typed) begin
         foreach (fresh[i]) tx_due.push_back(fresh[i]);
      end else if (kind == KIND_TICK) begin
         for (int i = 0; i < 8; i++) tx_due.push_back('{want[63 - 8*i -: 8], i == 7});
      end else begin
         tx_due.push_back('{want[7:0], 1'b1});
      end
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic settle(input int extra);
      req_valid <= 1'b0;
      do @(negedge clock); while (tx_due.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic set_tick_limit(input logic [TickW-1:0] value);
      settle(4);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tick_limit = value;
   endtask

   task automatic send_frame();
      logic [ByteW-1:0] len_byte;
      logic [ByteW-1:0] pay [8];
      int               count;
      int               n;
      int               hh;
      int               mm;
      int               ss;
      bit               as_time;
      bit               broken;
      send_beat(KIND_BYTE, HeadByte);
      if (want_long) begin
         len_byte = DigitBase + 8'd24;
         want_long = 1'b0;
      end else if ($urandom_range(99) < 70) begin
         len_byte = DigitBase + SetLength;
      end else begin
         len_byte = 8'($urandom_range(8'h30, 8'h3b));
      end
      send_beat(KIND_BYTE, len_byte);
      count   = int'(8'(len_byte - DigitBase));
      as_time = (count == 8) && ($urandom_range(99) < 80);
      broken  = $urandom_range(99) < 8;
      n       = broken ? $urandom_range(0, count) : count;
      hh = $urandom_range(0, 23);
      mm = $urandom_range(0, 59);
      ss = $urandom_range(0, 59);
      pay = '{8'(hh / 10) + DigitBase, 8'(hh % 10) + DigitBase, 8'($urandom),
              8'(mm / 10) + DigitBase, 8'(mm % 10) + DigitBase, 8'($urandom),
              8'(ss / 10) + DigitBase, 8'(ss % 10) + DigitBase};
      for (int i = 0; i < n; i++) begin
         if (as_time) send_beat(KIND_BYTE, pay[i]);
         else if ($urandom_range(99) < 50) send_beat(KIND_BYTE, 8'($urandom_range(0, 9)) + DigitBase);
         else send_beat(KIND_BYTE, 8'($urandom));
      end
      if (!broken)
         send_beat(KIND_BYTE, ($urandom_range(99) < 85) ? TailByte : 8'($urandom));
   endtask

   initial begin : stimulus
      int r;
      int phase_start;
      bit paused;
      foreach (payload[i]) payload[i] = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < ScriptLen; i++) begin
         if (Script[i].is_cfg) set_tick_limit(Script[i].data);
         else send_beat(Script[i].kind, Script[i].data[ByteW-1:0], Script[i].typed, Script[i].want);
      end

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_tick_limit(16'($urandom_range(1, 3)));
            1: set_tick_limit(16'd1);
            2: set_tick_limit(16'd0);
            3: set_tick_limit(16'hffff);
            4: set_tick_limit(16'($urandom_range(2, 6)));
            default: set_tick_limit(TicksPerSecondReset);
         endcase
         steady_run = (p == 0);
         want_long  = (p == 4);
         if (p == 1) hold_off_ask = 1'b1;
         phase_start = beats_sent;
         paused = 1'b0;
         while (beats_sent - phase_start < 20) begin
            if (p == 2 && !paused && beats_sent - phase_start >= 10) begin
               settle(0);
               paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 55) send_frame();
            else if (r < 85) repeat ($urandom_range(1, 4)) send_beat(KIND_TICK, 8'($urandom));
            else send_beat(KIND_BYTE, 8'($urandom));
         end
      end
      steady_run = 1'b0;

      settle(8);
      if (mismatches == 0 && tx_due.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
design/tdc_pkg.sv
design/tdc_time_core.sv
design/tdc_tx_serializer.sv
design/serial_settable_time_of_day_clock_core.sv
design/tdc_checker.sv
verif/serial_settable_time_of_day_clock_core_test.sv
